/* rtl/core/scu_pkg.sv */
package scu_pkg;

  // default geometry
  localparam int NUM_SETS_DEF     = 256;
  localparam int SET_CAPACITY_DEF = 64;

  // field widths
  localparam int FUNC_W   = 2;
  localparam int SET_IN_W = 8;
  localparam int POS_W    = 6;
  localparam int LINK_W   = 7;
  localparam int COST_W   = 16;
  localparam int CNT_W    = 7;
  localparam int EFF_W    = 24;
  localparam int FRAC_W   = 8;

  // reciprocal table for the efficiency divide
  localparam int RECIP_W  = 32;
  localparam int CNT_VALS = 1 << CNT_W;
  localparam int POS_VALS = 1 << POS_W;
  localparam int SET_VALS = 1 << SET_IN_W;
  localparam int PROD_W   = EFF_W + RECIP_W;
  localparam int QD_W     = EFF_W + CNT_W;

  localparam logic [LINK_W-1:0] LINK_NONE = '1;
  localparam logic [EFF_W-1:0]  EFF_ONES  = '1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LINK   = 2'd0,
    FUNC_HDR    = 2'd1,
    FUNC_REMOVE = 2'd2
  } func_t;

  typedef struct packed {
    logic [LINK_W-1:0] prv;
    logic [LINK_W-1:0] nxt;
  } link_t;

  typedef struct packed {
    logic [LINK_W-1:0] root;
    logic [CNT_W-1:0]  cnt;
    logic [COST_W-1:0] cost;
    logic [EFF_W-1:0]  eff;
  } hdr_t;

endpackage

/* rtl/core/set_cover_element_unlink.sv */
// Element unlink engine for greedy set cover.
// Input channel (in_valid/in_ready) takes one word per item: a link load, a
// set header load or the removal of one (set, slot) occurrence of an element.
// Result channel (out_valid/out_ready) returns exactly one word per item: the
// running minimum efficiency and its set, plus the addressed set's header
// (efficiency, root, remaining count), the zero-count flag and, for a removal,
// the echoed last_of_element mark.
// Timing: an item is taken when the block is idle; it passes through the read
// step and the final step, and its result is registered as the final step ends;
// no new word is taken before then. The work is the read of the link and header
// memories, a reciprocal multiply and a multiply-back correction step.
// Each memory has a single port per cycle, so the two link updates of an
// unlink go out in separate cycles.
// Reset (synchronous, rst_n low) clears the control state, sets the running
// minimum to all ones and its set to zero; memory contents are undefined until
// loaded. When the receiver stalls the result waits in the output register;
// the block still takes the next word and holds it at the final step until
// the output register is free.
module set_cover_element_unlink #(
  parameter int NUM_SETS     = scu_pkg::NUM_SETS_DEF,
  parameter int SET_CAPACITY = scu_pkg::SET_CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [scu_pkg::FUNC_W-1:0]          in_func,
  input  logic [scu_pkg::SET_IN_W-1:0]        in_set_index,
  input  logic [scu_pkg::POS_W-1:0]           in_position,
  input  logic signed [scu_pkg::LINK_W-1:0]   in_link_prev,
  input  logic signed [scu_pkg::LINK_W-1:0]   in_link_next,
  input  logic [scu_pkg::COST_W-1:0]          in_cost,
  input  logic [scu_pkg::CNT_W-1:0]           in_count,
  input  logic signed [scu_pkg::LINK_W-1:0]   in_root,
  input  logic                                in_min_restart,
  input  logic                                in_last_of_element,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [scu_pkg::EFF_W-1:0]           out_min_efficiency,
  output logic [scu_pkg::SET_IN_W-1:0]        out_min_set,
  output logic [scu_pkg::EFF_W-1:0]           out_set_efficiency,
  output logic signed [scu_pkg::LINK_W-1:0]   out_new_root,
  output logic [scu_pkg::CNT_W-1:0]           out_remaining,
  output logic                                out_status,
  output logic                                out_done_res
);

  import scu_pkg::*;

  localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int SLOT_W = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
  localparam int SLOTS = NUM_SETS * SET_CAPACITY;
  localparam int AW = $clog2(SLOTS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD   = 3'b010,
    S_DIV  = 3'b100
  } state_t;

  // constant tables
  logic [RECIP_W-1:0] recip_tab    [CNT_VALS];
  logic [SET_W-1:0]   set_mod_tab  [SET_VALS];
  logic [SLOT_W-1:0]  slot_mod_tab [POS_VALS];

  for (genvar G = 0; G < CNT_VALS; G++) begin : g_recip
    localparam logic [RECIP_W-1:0] RecipVal =
      (G == 0) ? '0 : RECIP_W'(64'hFFFF_FFFF / ((G == 0) ? 1 : G));
    assign recip_tab[G] = RecipVal;
  end

  for (genvar G = 0; G < SET_VALS; G++) begin : g_set_mod
    localparam logic [SET_W-1:0] SetVal = SET_W'(G % NUM_SETS);
    assign set_mod_tab[G] = SetVal;
  end

  for (genvar G = 0; G < POS_VALS; G++) begin : g_slot_mod
    localparam logic [SLOT_W-1:0] SlotVal = SLOT_W'(G % SET_CAPACITY);
    assign slot_mod_tab[G] = SlotVal;
  end

  function automatic logic [AW-1:0] slot_addr(input logic [SET_W-1:0] s,
                                              input logic [SLOT_W-1:0] p);
    return AW'(AW'(s) * AW'(SET_CAPACITY)) + AW'(p);
  endfunction

  // memories
  link_t link_mem [SLOTS];
  hdr_t  hdr_mem  [NUM_SETS];

  state_t state_r, state_nxt;

  logic [FUNC_W-1:0]   func_r;
  logic [SET_W-1:0]    set_r;
  logic [POS_W-1:0]    pos_r;
  logic [LINK_W-1:0]   prev_in_r, next_in_r, root_in_r;
  logic [COST_W-1:0]   cost_in_r;
  logic [CNT_W-1:0]    count_in_r;
  logic                restart_r, last_r;
  link_t               link_rd_r;
  hdr_t                hdr_rd_r;

  logic [EFF_W-1:0]    div_n_r;
  logic [CNT_W-1:0]    div_d_r;
  logic [PROD_W-1:0]   prod_r;

  logic [EFF_W-1:0]    min_r;
  logic [SET_IN_W-1:0] min_set_r;

  logic                out_valid_r;
  logic [EFF_W-1:0]    out_min_eff_r, out_set_eff_r;
  logic [SET_IN_W-1:0] out_min_set_r;
  logic [LINK_W-1:0]   out_root_r;
  logic [CNT_W-1:0]    out_rem_r;
  logic                out_status_r, out_done_r;

  logic                acc, go;
  logic [SET_W-1:0]    in_set_w;
  logic [AW-1:0]       rd_addr, here, addr_pv, addr_nx;

  // unlink decode
  logic                is_root, cnt_zero;
  logic [LINK_W-1:0]   root_new, nxt_wr_val, prv_wr_val;
  logic                nxt_wr_en, prv_wr_en;
  logic [CNT_W-1:0]    cnt_new;

  // divide
  logic [EFF_W-1:0]    q0, quo, eff_calc;
  logic [QD_W-1:0]     qd, div_rem;

  // running minimum
  logic [EFF_W-1:0]    min_base, min_upd;
  logic [SET_IN_W-1:0] min_set_upd;

  // link memory write port
  logic                lk_we_prv, lk_we_nxt;
  logic [AW-1:0]       lk_wa;
  link_t               lk_wd;

  assign acc      = in_valid && in_ready;
  assign go       = (state_r == S_DIV) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == S_IDLE);

  assign in_set_w = set_mod_tab[in_set_index];
  assign rd_addr  = slot_addr(in_set_w, slot_mod_tab[in_position]);
  assign here     = slot_addr(set_r, slot_mod_tab[pos_r]);
  assign addr_pv  = slot_addr(set_r, slot_mod_tab[link_rd_r.prv[POS_W-1:0]]);
  assign addr_nx  = slot_addr(set_r, slot_mod_tab[link_rd_r.nxt[POS_W-1:0]]);

  always_comb begin
    is_root    = !hdr_rd_r.root[LINK_W-1] && (hdr_rd_r.root == {1'b0, pos_r});
    root_new   = hdr_rd_r.root;
    if (is_root) begin
      root_new = link_rd_r.nxt[LINK_W-1] ? LINK_NONE : link_rd_r.nxt;
    end
    nxt_wr_en  = !is_root && !link_rd_r.prv[LINK_W-1];
    nxt_wr_val = link_rd_r.nxt[LINK_W-1] ? LINK_NONE : link_rd_r.nxt;
    prv_wr_en  = !is_root && !link_rd_r.nxt[LINK_W-1];
    prv_wr_val = link_rd_r.prv[LINK_W-1] ? LINK_NONE : link_rd_r.prv;
    cnt_zero   = (hdr_rd_r.cnt == '0);
    cnt_new    = cnt_zero ? '0 : hdr_rd_r.cnt - CNT_W'(1);
  end

  // quotient estimate is exact or one short
  always_comb begin
    q0       = prod_r[PROD_W-1 -: EFF_W];
    qd       = QD_W'(q0) * QD_W'(div_d_r);
    div_rem  = QD_W'(div_n_r) - qd;
    quo      = q0 + EFF_W'(div_rem >= QD_W'(div_d_r));
    eff_calc = (div_d_r == '0) ? EFF_ONES : quo;
  end

  always_comb begin
    min_base    = restart_r ? EFF_ONES : min_r;
    min_upd     = min_base;
    min_set_upd = min_set_r;
    if (eff_calc < min_base) begin
      min_upd     = eff_calc;
      min_set_upd = SET_IN_W'(set_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (acc) state_nxt = S_RD;
      S_RD:    state_nxt = S_DIV;
      S_DIV:   if (go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    lk_we_prv = 1'b0;
    lk_we_nxt = 1'b0;
    lk_wa     = here;
    lk_wd     = '{prv: prev_in_r, nxt: next_in_r};
    if (state_r == S_RD) begin
      if (func_r == FUNC_LINK) begin
        lk_we_prv = 1'b1;
        lk_we_nxt = 1'b1;
      end else if (func_r == FUNC_REMOVE && nxt_wr_en) begin
        lk_we_nxt = 1'b1;
        lk_wa     = addr_pv;
        lk_wd.nxt = nxt_wr_val;
      end
    end else if (go && func_r == FUNC_REMOVE && prv_wr_en) begin
      lk_we_prv = 1'b1;
      lk_wa     = addr_nx;
      lk_wd.prv = prv_wr_val;
    end
  end

  // link memory: one address per cycle, lane write enables
  always_ff @(posedge clk) begin
    if (lk_we_prv) begin
      link_mem[lk_wa].prv <= lk_wd.prv;
    end
    if (lk_we_nxt) begin
      link_mem[lk_wa].nxt <= lk_wd.nxt;
    end
    if (acc) begin
      link_rd_r <= link_mem[rd_addr];
    end
  end

  // header memory
  always_ff @(posedge clk) begin
    if (go && func_r == FUNC_REMOVE) begin
      hdr_mem[set_r] <= '{root: root_new, cnt: cnt_new, cost: hdr_rd_r.cost,
                          eff: eff_calc};
    end else if (go && func_r == FUNC_HDR) begin
      hdr_mem[set_r] <= '{root: root_in_r, cnt: count_in_r, cost: cost_in_r,
                          eff: eff_calc};
    end
    if (acc) begin
      hdr_rd_r <= hdr_mem[in_set_w];
    end
  end

  // captured word and divider operands
  always_ff @(posedge clk) begin
    if (acc) begin
      func_r     <= in_func;
      set_r      <= in_set_w;
      pos_r      <= in_position;
      prev_in_r  <= in_link_prev;
      next_in_r  <= in_link_next;
      root_in_r  <= in_root;
      cost_in_r  <= in_cost;
      count_in_r <= in_count;
      restart_r  <= in_min_restart;
      last_r     <= in_last_of_element;
    end
    if (state_r == S_RD) begin
      if (func_r == FUNC_HDR) begin
        div_n_r <= {cost_in_r, FRAC_W'(0)};
        div_d_r <= count_in_r;
        prod_r  <= PROD_W'({cost_in_r, FRAC_W'(0)}) * PROD_W'(recip_tab[count_in_r]);
      end else begin
        div_n_r <= {hdr_rd_r.cost, FRAC_W'(0)};
        div_d_r <= cnt_new;
        prod_r  <= PROD_W'({hdr_rd_r.cost, FRAC_W'(0)}) * PROD_W'(recip_tab[cnt_new]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      min_r       <= EFF_ONES;
      min_set_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (go && func_r == FUNC_REMOVE) begin
        min_r     <= min_upd;
        min_set_r <= min_set_upd;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (go) begin
      case (func_r)
        FUNC_REMOVE: begin
          out_min_eff_r <= min_upd;
          out_min_set_r <= min_set_upd;
          out_set_eff_r <= eff_calc;
          out_root_r    <= root_new;
          out_rem_r     <= cnt_new;
          out_status_r  <= cnt_zero;
          out_done_r    <= last_r;
        end
        FUNC_HDR: begin
          out_min_eff_r <= min_r;
          out_min_set_r <= min_set_r;
          out_set_eff_r <= eff_calc;
          out_root_r    <= root_in_r;
          out_rem_r     <= count_in_r;
          out_status_r  <= 1'b0;
          out_done_r    <= 1'b0;
        end
        default: begin
          out_min_eff_r <= min_r;
          out_min_set_r <= min_set_r;
          out_set_eff_r <= hdr_rd_r.eff;
          out_root_r    <= hdr_rd_r.root;
          out_rem_r     <= hdr_rd_r.cnt;
          out_status_r  <= 1'b0;
          out_done_r    <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_min_efficiency = out_min_eff_r;
  assign out_min_set        = out_min_set_r;
  assign out_set_efficiency = out_set_eff_r;
  assign out_new_root       = out_root_r;
  assign out_remaining      = out_rem_r;
  assign out_status         = out_status_r;
  assign out_done_res       = out_done_r;

  a_new_word_from_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DIV))
    else $error("result word appeared without a final step");

  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> state_r == S_RD)
    else $error("accepted word did not enter the read step");

  a_div_correction: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && div_d_r != '0) |-> div_rem < {QD_W'(div_d_r), 1'b0})
    else $error("reciprocal estimate off by more than one");

  a_zero_count_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |-> (out_rem_r == '0 && out_set_eff_r == EFF_ONES))
    else $error("zero-count flag with non-empty header");

  a_min_not_above_set: assert property (@(posedge clk) disable iff (!rst_n)
    (go && func_r == FUNC_REMOVE) |-> min_upd <= eff_calc)
    else $error("running minimum above the set just removed from");

endmodule
